[design/mp2d_pkg.sv]
// mp2d_pkg: shared constants and types for the max_pooling_2d block.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package mp2d_pkg;

	localparam int IN_WIDTH_W  = 11;
	localparam int IN_HEIGHT_W = 13;
	localparam int POOL_W      = 4;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_IDX_W   = 2;

	localparam int MAX_HEIGHT = 4096;
	localparam int MAX_POOL   = 8;
	localparam int ROW_W      = 12;
	localparam int OFS_W      = 3;

	localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE = 2'd2;

	localparam logic [IN_WIDTH_W-1:0]  RST_IN_WIDTH  = 11'd1024;
	localparam logic [IN_HEIGHT_W-1:0] RST_IN_HEIGHT = 13'd1024;
	localparam logic [POOL_W-1:0]      RST_POOL_SIZE = 4'd2;

	// per-beat op flags from position tracker to row store
	typedef struct packed {
		logic active;
		logic init;
		logic emit;
		logic last;
	} op_t;

endpackage

[design/mp2d_in_if.sv]
// mp2d_in_if: valid/ready channel for sample beats.
// Depends on nothing.
`timescale 1ns / 1ps

interface mp2d_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          first_of_map;

	modport source (output valid, output sample, output first_of_map, input ready);
	modport sink   (input valid, input sample, input first_of_map, output ready);
endinterface

[design/mp2d_out_if.sv]
// mp2d_out_if: valid/ready channel for pooled results.
// Depends on nothing.
`timescale 1ns / 1ps

interface mp2d_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] pooled_value;
	logic                          last_of_map;

	modport source (output valid, output pooled_value, output last_of_map, input ready);
	modport sink   (input valid, input pooled_value, input last_of_map, output ready);
endinterface

[design/mp2d_pos.sv]
// mp2d_pos: configuration registers and raster position tracking.
// Produces the row-store address and op flags for each accepted beat. Uses mp2d_pkg.
`timescale 1ns / 1ps

module mp2d_pos #(
	parameter int MAX_WIDTH = 1024,
	parameter int CW        = $clog2(MAX_WIDTH)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mp2d_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mp2d_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               accept,
	input  logic                               first_of_map,
	output mp2d_pkg::op_t                      op,
	output logic [CW-1:0]                      addr
);

	localparam int RW = mp2d_pkg::ROW_W;
	localparam int OW = mp2d_pkg::OFS_W;

	logic [mp2d_pkg::IN_WIDTH_W-1:0]  in_width_q;
	logic [mp2d_pkg::IN_HEIGHT_W-1:0] in_height_q;
	logic [mp2d_pkg::POOL_W-1:0]      pool_size_q;

	logic [CW-1:0] col_q, cstart_q, oc_q;
	logic [RW-1:0] row_q, rstart_q;
	logic [OW-1:0] wc_q, wr_q;

	logic [CW:0]   w_eff;
	logic [RW:0]   h_eff;
	logic [mp2d_pkg::POOL_W-1:0] p_eff;

	logic [CW-1:0] col_c, cstart_c, oc_c;
	logic [RW-1:0] row_c, rstart_c;
	logic [OW-1:0] wc_c, wr_c;

	logic [CW+1:0] cfit_sum, clast_sum;
	logic [RW+1:0] rfit_sum, rlast_sum;
	logic          col_fit, row_fit, col_lastwin, row_lastwin;
	logic          wc_end, wr_end;

	always_comb begin
		if (in_width_q == '0) begin
			w_eff = (CW+1)'(1);
		end else if ({3'b0, in_width_q} > 14'(MAX_WIDTH)) begin
			w_eff = (CW+1)'(MAX_WIDTH);
		end else begin
			w_eff = (CW+1)'(in_width_q);
		end
		if (in_height_q == '0) begin
			h_eff = (RW+1)'(1);
		end else if (in_height_q > (RW+1)'(mp2d_pkg::MAX_HEIGHT)) begin
			h_eff = (RW+1)'(mp2d_pkg::MAX_HEIGHT);
		end else begin
			h_eff = in_height_q;
		end
		if (pool_size_q == '0) begin
			p_eff = 4'd1;
		end else if (pool_size_q > 4'(mp2d_pkg::MAX_POOL)) begin
			p_eff = 4'(mp2d_pkg::MAX_POOL);
		end else begin
			p_eff = pool_size_q;
		end
	end

	// first_of_map restarts before the beat is taken in
	always_comb begin
		col_c    = first_of_map ? '0 : col_q;
		cstart_c = first_of_map ? '0 : cstart_q;
		oc_c     = first_of_map ? '0 : oc_q;
		row_c    = first_of_map ? '0 : row_q;
		rstart_c = first_of_map ? '0 : rstart_q;
		wc_c     = first_of_map ? '0 : wc_q;
		wr_c     = first_of_map ? '0 : wr_q;
	end

	// window fits when start + p <= extent; last window when start + 2p > extent
	always_comb begin
		cfit_sum    = (CW+2)'(cstart_c) + (CW+2)'(p_eff);
		clast_sum   = cfit_sum + (CW+2)'(p_eff);
		rfit_sum    = (RW+2)'(rstart_c) + (RW+2)'(p_eff);
		rlast_sum   = rfit_sum + (RW+2)'(p_eff);
		col_fit     = cfit_sum <= (CW+2)'(w_eff);
		row_fit     = rfit_sum <= (RW+2)'(h_eff);
		col_lastwin = clast_sum > (CW+2)'(w_eff);
		row_lastwin = rlast_sum > (RW+2)'(h_eff);
		wc_end      = ({1'b0, wc_c} + 4'd1) >= p_eff;
		wr_end      = ({1'b0, wr_c} + 4'd1) >= p_eff;
		op.active   = col_fit && row_fit;
		op.init     = (wc_c == '0) && (wr_c == '0);
		op.emit     = op.active && wc_end && wr_end;
		op.last     = op.emit && col_lastwin && row_lastwin;
		addr        = oc_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q  <= mp2d_pkg::RST_IN_WIDTH;
			in_height_q <= mp2d_pkg::RST_IN_HEIGHT;
			pool_size_q <= mp2d_pkg::RST_POOL_SIZE;
			col_q       <= '0;
			cstart_q    <= '0;
			oc_q        <= '0;
			row_q       <= '0;
			rstart_q    <= '0;
			wc_q        <= '0;
			wr_q        <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mp2d_pkg::REG_IN_WIDTH: begin
					in_width_q <= cfg_data[mp2d_pkg::IN_WIDTH_W-1:0];
				end
				mp2d_pkg::REG_IN_HEIGHT: begin
					in_height_q <= cfg_data;
				end
				mp2d_pkg::REG_POOL_SIZE: begin
					pool_size_q <= cfg_data[mp2d_pkg::POOL_W-1:0];
				end
				default: begin
				end
			endcase
			if (cfg_index == mp2d_pkg::REG_IN_WIDTH || cfg_index == mp2d_pkg::REG_IN_HEIGHT ||
			    cfg_index == mp2d_pkg::REG_POOL_SIZE) begin
				col_q    <= '0;
				cstart_q <= '0;
				oc_q     <= '0;
				row_q    <= '0;
				rstart_q <= '0;
				wc_q     <= '0;
				wr_q     <= '0;
			end
		end else if (accept) begin
			if ((CW+1)'(col_c) + (CW+1)'(1) >= w_eff) begin
				col_q    <= '0;
				cstart_q <= '0;
				oc_q     <= '0;
				wc_q     <= '0;
				if ((RW+1)'(row_c) + (RW+1)'(1) >= h_eff) begin
					row_q    <= '0;
					rstart_q <= '0;
					wr_q     <= '0;
				end else begin
					row_q <= row_c + RW'(1);
					if (wr_end) begin
						wr_q     <= '0;
						rstart_q <= rstart_c + RW'(p_eff);
					end else begin
						wr_q     <= wr_c + OW'(1);
						rstart_q <= rstart_c;
					end
				end
			end else begin
				col_q    <= col_c + CW'(1);
				row_q    <= row_c;
				rstart_q <= rstart_c;
				wr_q     <= wr_c;
				if (wc_end) begin
					wc_q     <= '0;
					oc_q     <= oc_c + CW'(1);
					cstart_q <= cstart_c + CW'(p_eff);
				end else begin
					wc_q     <= wc_c + OW'(1);
					oc_q     <= oc_c;
					cstart_q <= cstart_c;
				end
			end
		end
	end

endmodule

[design/mp2d_colmax.sv]
// mp2d_colmax: column-max row store with registered read, max update, write-back
// with forwarding, and the result register. Uses mp2d_pkg.
`timescale 1ns / 1ps

module mp2d_colmax #(
	parameter int MAX_WIDTH   = 1024,
	parameter int SAMPLE_BITS = 16,
	parameter int CW          = $clog2(MAX_WIDTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  mp2d_pkg::op_t                 op,
	input  logic [CW-1:0]                 addr,
	output logic                          ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_value,
	output logic                          out_last
);

	logic signed [SAMPLE_BITS-1:0] mem [MAX_WIDTH];

	logic                          valid_s1;
	mp2d_pkg::op_t                 op_s1;
	logic [CW-1:0]                 addr_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic signed [SAMPLE_BITS-1:0] rd_s1;
	logic                          fwd_s1;
	logic signed [SAMPLE_BITS-1:0] fwdd_s1;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_value_q;
	logic                          out_last_q;

	logic                          out_free, adv_s1, wr_en;
	logic signed [SAMPLE_BITS-1:0] prior, newval;

	always_comb begin
		out_free = !out_valid_q || out_ready;
		adv_s1   = valid_s1 && (!op_s1.emit || out_free);
		ready    = !valid_s1 || adv_s1;
		wr_en    = adv_s1 && op_s1.active;
		prior    = fwd_s1 ? fwdd_s1 : rd_s1;
		newval   = (op_s1.init || sample_s1 > prior) ? sample_s1 : prior;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= newval;
		end
		if (accept) begin
			rd_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			op_s1       <= '0;
			addr_s1     <= '0;
			sample_s1   <= '0;
			fwd_s1      <= 1'b0;
			fwdd_s1     <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1  <= 1'b1;
				op_s1     <= op;
				addr_s1   <= addr;
				sample_s1 <= sample;
				// write in flight to the same entry is missed by the read
				fwd_s1    <= wr_en && (addr_s1 == addr);
				fwdd_s1   <= newval;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1 && op_s1.emit) begin
				out_valid_q <= 1'b1;
				out_value_q <= newval;
				out_last_q  <= op_s1.last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

endmodule

[design/max_pooling_2d.sv]
// max_pooling_2d: non-overlapping square max pooling over raster-order maps.
// Depends on mp2d_pkg, mp2d_in_if, mp2d_out_if, mp2d_pos, mp2d_colmax.
//
//   channel   dir   beat payload
//   samples   in    sample, first_of_map
//   results   out   pooled_value, last_of_map
//   cfg_*     in    cfg_index, cfg_data (write only, cfg_we strobe)
//
// One sample beat per cycle unless a stalled result holds it back; the row store is read
// at accept and written as the beat leaves stage 1, with forwarding between neighboring
// beats on the same row-store entry. A result passes stage 1, then the output register.
// Reset restores register defaults and position zero; the row store is not cleared.
// A stalled result holds one beat in flight; samples stop only when that beat
// also needs the output register.
`timescale 1ns / 1ps

module max_pooling_2d #(
	parameter int MAX_WIDTH   = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mp2d_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mp2d_pkg::CFG_DATA_W-1:0] cfg_data,
	mp2d_in_if.sink                         samples,
	mp2d_out_if.source                      results
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic          accept, ready;
	mp2d_pkg::op_t op;
	logic [CW-1:0] addr;

	assign accept        = samples.valid && ready;
	assign samples.ready = ready;

	mp2d_pos #(
		.MAX_WIDTH(MAX_WIDTH),
		.CW(CW)
	) u_pos (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.accept(accept),
		.first_of_map(samples.first_of_map),
		.op(op),
		.addr(addr)
	);

	mp2d_colmax #(
		.MAX_WIDTH(MAX_WIDTH),
		.SAMPLE_BITS(SAMPLE_BITS),
		.CW(CW)
	) u_colmax (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.sample(samples.sample),
		.op(op),
		.addr(addr),
		.ready(ready),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.out_value(results.pooled_value),
		.out_last(results.last_of_map)
	);

endmodule
